FILE: hw/rtl/mpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_pkg
// shared types and codes for the unordered minimum priority queue
// ----------------------------------------------------------------------------
package mpq_pkg;

	localparam int VALUE_W = 32;
	localparam int STATUS_W = 2;
	localparam int OCC_W = 5;
	localparam int OUT_DATA_W = 40;

	// operation codes carried on s_tuser
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIX,
		S_RESULT
	} state_t;

endpackage

FILE: hw/rtl/mpq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpq_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module mpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: hw/rtl/min_priority_queue_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_priority_queue_scan
// bounded unordered minimum priority queue, entries kept in one ram
// ----------------------------------------------------------------------------
//
// channel  dir  tdata                                   tuser
// s_*      in   [31:0] value                            [0] operation
// m_*      out  [31:0] removed_value, [36:32] occupancy  [1:0] status
//               [37] queue_empty, [39:38] zero
//
// sequence: an insert, a full insert or an empty remove goes from accept
//   through S_RESULT to the result register; a remove issues one ram read
//   per held entry in S_SCAN, takes the last read in S_DRAIN, writes the
//   hole fill in S_FIX and loads the result from S_RESULT once the output register is free
// reset: count and control clear at once, no clearing pass over the ram
// stalls: one transaction is in work at a time; a new one is taken while
//   the previous result still waits in the output register
//
module min_priority_queue_scan #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// input transactions
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic        s_tuser,   // [0] operation
	// result transactions
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] removed_value, [36:32] occupancy, [37] queue_empty
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	mpq_pkg::state_t state_q, state_d;

	// held entry count
	logic [CNT_W-1:0] count_q;

	// scan bookkeeping
	logic [IDX_W-1:0] scan_q;
	logic             vld_s1;
	logic [IDX_W-1:0] addr_s1;
	logic [31:0]      best_val_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [31:0]      last_val_q;

	// result waiting for the output register
	mpq_pkg::status_t res_status_q;
	logic [31:0]      res_value_q;

	// output register
	logic             m_tvalid_q;
	mpq_pkg::status_t out_status_q;
	logic [31:0]      out_value_q;
	logic [4:0]       out_occ_q;
	logic             out_empty_q;

	// ram controls
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [31:0]      wr_data;
	logic             rd_en;
	logic [31:0]      rd_data;

	logic accept;
	logic out_free;
	logic load_out;
	logic is_full;
	logic is_empty;
	logic scan_last;
	logic take_best;

	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign is_full   = (count_q >= CNT_W'(CAPACITY));
	assign is_empty  = (count_q == '0);
	assign scan_last = ((CNT_W'(scan_q) + CNT_W'(1)) == count_q);
	// first returned entry seeds the minimum, later ones replace it if smaller
	assign take_best = (addr_s1 == '0) || ($signed(rd_data) < $signed(best_val_q));

	mpq_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (scan_q),
		.rd_data (rd_data)
	);

	// next state and ram controls; reads and writes never touch the ram in
	// the same cycle, since the fill write comes only after the scan drains
	always_comb begin
		state_d  = state_q;
		wr_en    = 1'b0;
		wr_addr  = IDX_W'(count_q);
		wr_data  = s_tdata;
		rd_en    = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			mpq_pkg::S_IDLE: begin
				if (accept) begin
					if (s_tuser == mpq_pkg::OP_INSERT) begin
						// store in the next free slot unless full
						wr_en   = !is_full;
						state_d = mpq_pkg::S_RESULT;
					end else if (is_empty) begin
						state_d = mpq_pkg::S_RESULT;
					end else begin
						state_d = mpq_pkg::S_SCAN;
					end
				end
			end
			mpq_pkg::S_SCAN: begin
				rd_en = 1'b1;
				if (scan_last) begin
					state_d = mpq_pkg::S_DRAIN;
				end
			end
			mpq_pkg::S_DRAIN: begin
				state_d = mpq_pkg::S_FIX;
			end
			mpq_pkg::S_FIX: begin
				// move the last held entry into the hole
				wr_en   = 1'b1;
				wr_addr = best_idx_q;
				wr_data = last_val_q;
				state_d = mpq_pkg::S_RESULT;
			end
			mpq_pkg::S_RESULT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = mpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = mpq_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= mpq_pkg::S_IDLE;
			count_q    <= '0;
			scan_q     <= '0;
			vld_s1     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= rd_en;
			if (state_q == mpq_pkg::S_IDLE && accept) begin
				scan_q <= '0;
				if (s_tuser == mpq_pkg::OP_INSERT && !is_full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (state_q == mpq_pkg::S_SCAN && !scan_last) begin
				scan_q <= scan_q + IDX_W'(1);
			end
			if (state_q == mpq_pkg::S_FIX) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= scan_q;
		if (vld_s1) begin
			if (take_best) begin
				best_val_q <= rd_data;
				best_idx_q <= addr_s1;
			end
			// the final read of the scan is the last held entry
			last_val_q <= rd_data;
		end
		if (state_q == mpq_pkg::S_IDLE && accept) begin
			res_value_q <= '0;
			if (s_tuser == mpq_pkg::OP_INSERT) begin
				res_status_q <= is_full ? mpq_pkg::ST_FULL : mpq_pkg::ST_OK;
			end else begin
				res_status_q <= is_empty ? mpq_pkg::ST_EMPTY : mpq_pkg::ST_OK;
			end
		end
		if (state_q == mpq_pkg::S_FIX) begin
			res_value_q <= best_val_q;
		end
		if (load_out) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_occ_q    <= 5'(count_q);
			out_empty_q  <= is_empty;
		end
	end

	assign s_tready = (state_q == mpq_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {2'b00, out_empty_q, out_occ_q, out_value_q};

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the unordered minimum priority queue
// ----------------------------------------------------------------------------
// a queue of insert and remove transactions is built up front: a short
// directed opening covers the extremes, remove on empty, insert on full and
// equal minima, then random bursts lean toward filling or draining the
// queue or are evenly mixed. a clocked driver sends them with random gaps,
// and a mirror of the queue works out the status, removed value, occupancy
// and empty flag of each accepted transaction. a clocked monitor stalls at
// random and checks every result against the oldest outstanding outcome
// ----------------------------------------------------------------------------
module testbench;

	localparam int CAPACITY = 16;
	localparam int RANDOM_OPS = 700;

	typedef struct packed {
		logic        op;
		logic [31:0] value;
		logic [1:0]  phase;       // 0 and 1 gaps on both sides, idle rates swapped, 2 no gaps
		logic        wait_drain;  // hold off until every outcome has arrived
	} queue_op_t;

	typedef struct packed {
		mpq_pkg::status_t status;
		logic [31:0]      removed;
		logic [4:0]       occupancy;
		logic             empty;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tuser = mpq_pkg::OP_INSERT;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;

	queue_op_t ops_to_send[$];
	outcome_t  outcomes_due[$];
	queue_op_t in_flight;
	int        total_ops;
	int        ops_accepted = 0;
	int        fail_count = 0;
	int        run_phase = 0;

	// mirror of the queue contents
	logic signed [31:0] mirror_entries[CAPACITY];
	int                 mirror_count = 0;

	min_priority_queue_scan #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// one line per mismatch
	task automatic report(input string field, input logic [39:0] want,
			input logic [39:0] got);
		fail_count++;
		$display("mismatch %s: expected %h got %h at %0t", field, want, got, $realtime);
	endtask

	// applies one transaction to the mirror and returns what the block must answer
	function automatic outcome_t apply_queue_op(input queue_op_t q);
		outcome_t res;
		int best;
		res.status = mpq_pkg::ST_OK;
		res.removed = '0;
		if (q.op == mpq_pkg::OP_INSERT) begin
			if (mirror_count >= CAPACITY) begin
				res.status = mpq_pkg::ST_FULL;
			end else begin
				mirror_entries[mirror_count] = q.value;
				mirror_count++;
			end
		end else if (mirror_count == 0) begin
			res.status = mpq_pkg::ST_EMPTY;
		end else begin
			// scan for the smallest signed entry, the first one wins on ties
			best = 0;
			for (int i = 1; i < mirror_count; i++)
				if (mirror_entries[i] < mirror_entries[best])
					best = i;
			res.removed = mirror_entries[best];
			mirror_count--;
			// the last held entry fills the hole
			mirror_entries[best] = mirror_entries[mirror_count];
		end
		res.occupancy = mirror_count[4:0];
		res.empty = (mirror_count == 0);
		return res;
	endfunction

	function automatic int sender_idle_pct(input logic [1:0] ph);
		case (ph)
			2'd0: return 34;
			2'd1: return 48;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct(input int ph);
		case (ph)
			0: return 48;
			1: return 34;
			default: return 0;
		endcase
	endfunction

	// value mix: full range, a narrow band so equal minima are common, a wider band, extremes
	function automatic logic [31:0] random_value();
		logic [31:0] v;
		case ($urandom_range(9))
			5, 6, 7: v = $urandom_range(15) - 8;
			8: begin
				case ($urandom_range(4))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'hffff_ffff;
					3: v = 32'h0000_0001;
					default: v = 32'h0000_0000;
				endcase
			end
			9: v = $urandom_range(2000) - 1000;
			default: v = $urandom;
		endcase
		return v;
	endfunction

	task automatic add_op(input logic op, input logic [31:0] value);
		queue_op_t q;
		q.op = op;
		q.value = value;
		q.phase = 2'd0;
		q.wait_drain = 1'b0;
		ops_to_send.push_back(q);
	endtask

	// driver: one new transaction may be offered once the previous one is taken
	always @(posedge clk or negedge arst_n) begin
		logic holding;
		logic go;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			holding = s_tvalid;
			if (s_tvalid && s_tready) begin
				outcomes_due.push_back(apply_queue_op(in_flight));
				ops_accepted++;
				holding = 1'b0;
			end
			if (!holding) begin
				go = 1'b0;
				if (ops_to_send.size() != 0) begin
					// a drain point waits until the block has answered everything
					if (!(ops_to_send[0].wait_drain && outcomes_due.size() != 0))
						go = ($urandom_range(99) >= sender_idle_pct(ops_to_send[0].phase));
				end
				if (go) begin
					in_flight = ops_to_send.pop_front();
					run_phase = in_flight.phase;
					s_tvalid <= 1'b1;
					s_tdata <= in_flight.value;
					s_tuser <= in_flight.op;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest outcome
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (outcomes_due.size() == 0) begin
					report("result with nothing outstanding", '0, m_tdata);
				end else begin
					want = outcomes_due.pop_front();
					if (m_tuser !== want.status)
						report("status", 40'(want.status), 40'(m_tuser));
					if (m_tdata[31:0] !== want.removed)
						report("removed_value", 40'(want.removed), 40'(m_tdata[31:0]));
					if (m_tdata[36:32] !== want.occupancy)
						report("occupancy", 40'(want.occupancy), 40'(m_tdata[36:32]));
					if (m_tdata[37] !== want.empty)
						report("queue_empty", 40'(want.empty), 40'(m_tdata[37]));
					if (m_tdata[39:38] !== 2'b00)
						report("tdata padding", '0, 40'(m_tdata[39:38]));
				end
			end
			m_tready <= ($urandom_range(99) >= receiver_idle_pct(run_phase));
		end
	end

	initial begin
		int burst_len;
		int insert_pct;
		int ph;
		// remove on empty, then extremes with a repeated minimum
		add_op(mpq_pkg::OP_REMOVE, 32'h0);
		add_op(mpq_pkg::OP_INSERT, 32'h7fff_ffff);
		add_op(mpq_pkg::OP_INSERT, 32'h8000_0000);
		add_op(mpq_pkg::OP_INSERT, 32'h0000_0000);
		add_op(mpq_pkg::OP_INSERT, 32'hffff_ffff);
		add_op(mpq_pkg::OP_INSERT, 32'h8000_0000);
		add_op(mpq_pkg::OP_REMOVE, 32'hdead_beef);
		add_op(mpq_pkg::OP_REMOVE, 32'h0);
		add_op(mpq_pkg::OP_REMOVE, 32'hffff_ffff);
		// fill up from two held entries, then two inserts into a full queue
		for (int i = 0; i < CAPACITY - 2; i++)
			add_op(mpq_pkg::OP_INSERT, $urandom);
		add_op(mpq_pkg::OP_INSERT, 32'h5555_5555);
		add_op(mpq_pkg::OP_INSERT, 32'haaaa_aaaa);

		// random bursts biased to fill, to drain, or evenly mixed
		while (ops_to_send.size() < 25 + RANDOM_OPS) begin
			burst_len = $urandom_range(40, 4);
			case ($urandom_range(2))
				0: insert_pct = 85;
				1: insert_pct = 15;
				default: insert_pct = 50;
			endcase
			for (int i = 0; i < burst_len; i++) begin
				if ($urandom_range(99) < insert_pct)
					add_op(mpq_pkg::OP_INSERT, random_value());
				else
					add_op(mpq_pkg::OP_REMOVE, $urandom);
			end
		end

		// split the run into three idling phases, each opening on an idle block, plus random drain points
		total_ops = ops_to_send.size();
		for (int i = 0; i < total_ops; i++) begin
			ph = i * 3 / total_ops;
			ops_to_send[i].phase = ph[1:0];
			if (i > 0 && ph != (i - 1) * 3 / total_ops)
				ops_to_send[i].wait_drain = 1'b1;
			else if (i > 25 && $urandom_range(59) == 0)
				ops_to_send[i].wait_drain = 1'b1;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (ops_accepted != total_ops || outcomes_due.size() != 0);
		// longest remove plus margin, to catch any stray result
		repeat (CAPACITY + 12) @(posedge clk);

		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// far above the slowest correct run
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: min_priority_queue_scan.f
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_ram.sv
hw/rtl/min_priority_queue_scan.sv
tb/testbench.sv
